/* rtl/core/hvn_pkg.sv */
// Shared constants and item types for the heightmap vertex normal block.
// Used by heightmap_vertex_normal, hvn_sqrt and hvn_div; no dependencies.
package hvn_pkg;

  localparam int HEIGHT_BITS      = 16;
  localparam int HEIGHT_FRAC_BITS = 8;

  localparam int MASK_BITS      = 4;
  localparam int EDGE_FIRST_ROW = 0;
  localparam int EDGE_LAST_ROW  = 1;
  localparam int EDGE_FIRST_COL = 2;
  localparam int EDGE_LAST_COL  = 3;

  localparam int DIFF_BITS = HEIGHT_BITS + 1;
  localparam int SUM_BITS  = HEIGHT_BITS + 4;
  localparam int MAG_BITS  = SUM_BITS - 1;
  localparam int CNT_BITS  = 3;
  localparam int AZ_BITS   = HEIGHT_FRAC_BITS + CNT_BITS;
  localparam int LZ_BITS   = (MAG_BITS > AZ_BITS) ? MAG_BITS : AZ_BITS;
  localparam int POS_BITS  = $clog2(LZ_BITS);

  localparam int NORM_BITS = 24;
  localparam int SQ_BITS   = 2 * NORM_BITS;
  localparam int LEN2_BITS = SQ_BITS + 2;
  localparam int ROOT_BITS = NORM_BITS + 1;

  localparam int OUT_FRAC = 14;
  localparam int UNIT_OUT = 1 << OUT_FRAC;
  localparam int Q_BITS   = OUT_FRAC + 1;
  localparam int NUM_BITS = NORM_BITS + OUT_FRAC + 1;
  localparam int NXY_BITS = 16;
  localparam int NZ_BITS  = 15;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] h_nw;
    logic signed [HEIGHT_BITS-1:0] h_n;
    logic signed [HEIGHT_BITS-1:0] h_ne;
    logic signed [HEIGHT_BITS-1:0] h_w;
    logic signed [HEIGHT_BITS-1:0] h_c;
    logic signed [HEIGHT_BITS-1:0] h_e;
    logic signed [HEIGHT_BITS-1:0] h_sw;
    logic signed [HEIGHT_BITS-1:0] h_s;
    logic signed [HEIGHT_BITS-1:0] h_se;
    logic [MASK_BITS-1:0]          edge_mask;
  } in_t;

  typedef struct packed {
    logic signed [NXY_BITS-1:0] normal_x;
    logic signed [NXY_BITS-1:0] normal_y;
    logic [NZ_BITS-1:0]         normal_z;
  } out_t;

  // normalized magnitudes and signs of the summed normal
  typedef struct packed {
    logic                 nx;
    logic                 ny;
    logic [NORM_BITS-1:0] ax;
    logic [NORM_BITS-1:0] ay;
    logic [NORM_BITS-1:0] az;
  } vec_t;

endpackage

/* rtl/core/heightmap_vertex_normal.sv */
// Heightmap vertex normal: sums adjacent triangle normals and scales to unit length.
// Depends on hvn_pkg, hvn_sqrt and hvn_div.
// Stages: 7 front stages, 25 root stages (one root bit each), 17 divide stages
// (one quotient bit each plus numerator and sign stages). One item per cycle unless
// stalled: the whole pipeline holds while a result waits at the output register.
// Reset (rst_ni low, async) clears all valid bits; data registers are not reset.
module heightmap_vertex_normal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hvn_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hvn_pkg::out_t out_data_o
);

  localparam int DiffW = hvn_pkg::DIFF_BITS;
  localparam int SumW  = hvn_pkg::SUM_BITS;
  localparam int MagW  = hvn_pkg::MAG_BITS;
  localparam int CntW  = hvn_pkg::CNT_BITS;
  localparam int AzW   = hvn_pkg::AZ_BITS;
  localparam int LzW   = hvn_pkg::LZ_BITS;
  localparam int PosW  = hvn_pkg::POS_BITS;
  localparam int NormW = hvn_pkg::NORM_BITS;
  localparam int SqW   = hvn_pkg::SQ_BITS;
  localparam int Len2W = hvn_pkg::LEN2_BITS;
  localparam int Unit  = hvn_pkg::UNIT_OUT;

  logic en;

  // stage 1: height differences and triangle presence
  logic                    s1_v_q;
  logic                    ul_q, ur_q, dl_q, dr_q;
  logic signed [DiffW-1:0] d_cw_q, d_nen_q, d_ec_q, d_ssw_q;
  logic signed [DiffW-1:0] d_cn_q, d_ene_q, d_sww_q, d_sc_q;
  logic                    up, down, left, right;

  // stage 2: sums
  logic                   s2_v_q;
  logic signed [SumW-1:0] sx_d, sy_d, sx_q, sy_q;
  logic [CntW-1:0]        cnt, cnt_nz;
  logic [AzW-1:0]         az_d, az_q;

  // stage 3: magnitudes
  logic            s3_v_q;
  logic [SumW-1:0] abx, aby;
  logic            nx3_q, ny3_q;
  logic [LzW-1:0]  ax3_q, ay3_q, az3_q;

  // stage 4: leading one position
  logic            s4_v_q;
  logic [LzW-1:0]  orv;
  logic [PosW-1:0] pos_d, pos_q;
  logic            nx4_q, ny4_q;
  logic [LzW-1:0]  ax4_q, ay4_q, az4_q;

  // stages 5 to 7: normalize, square, sum
  logic               s5_v_q, s6_v_q, s7_v_q;
  hvn_pkg::vec_t      vec5_q, vec6_q, vec7_q;
  logic [SqW-1:0]     sqx_q, sqy_q, sqz_q;
  logic [Len2W-1:0]   len2_q;

  logic                          sq_v;
  logic [hvn_pkg::ROOT_BITS-1:0] root;
  hvn_pkg::vec_t                 sq_vec;

  function automatic logic [NormW-1:0] norm_shift(input logic [LzW-1:0]  v,
                                                  input logic [PosW-1:0] p);
    logic [LzW+NormW-2:0] w;
    w = {v, {(NormW-1){1'b0}}} >> p;
    return w[NormW-1:0];
  endfunction

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign up    = !in_data_i.edge_mask[hvn_pkg::EDGE_FIRST_ROW];
  assign down  = !in_data_i.edge_mask[hvn_pkg::EDGE_LAST_ROW];
  assign left  = !in_data_i.edge_mask[hvn_pkg::EDGE_FIRST_COL];
  assign right = !in_data_i.edge_mask[hvn_pkg::EDGE_LAST_COL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ul_q    <= up && left;
      ur_q    <= up && right;
      dl_q    <= down && left;
      dr_q    <= down && right;
      d_cw_q  <= DiffW'(in_data_i.h_c)  - DiffW'(in_data_i.h_w);
      d_nen_q <= DiffW'(in_data_i.h_ne) - DiffW'(in_data_i.h_n);
      d_ec_q  <= DiffW'(in_data_i.h_e)  - DiffW'(in_data_i.h_c);
      d_ssw_q <= DiffW'(in_data_i.h_s)  - DiffW'(in_data_i.h_sw);
      d_cn_q  <= DiffW'(in_data_i.h_c)  - DiffW'(in_data_i.h_n);
      d_ene_q <= DiffW'(in_data_i.h_e)  - DiffW'(in_data_i.h_ne);
      d_sww_q <= DiffW'(in_data_i.h_sw) - DiffW'(in_data_i.h_w);
      d_sc_q  <= DiffW'(in_data_i.h_s)  - DiffW'(in_data_i.h_c);
    end
  end

  always_comb begin
    sx_d = '0;
    sy_d = '0;
    if (ul_q) begin
      sx_d = sx_d - SumW'(d_cw_q);
      sy_d = sy_d - SumW'(d_cn_q);
    end
    if (ur_q) begin
      sx_d = sx_d - SumW'(d_nen_q) - SumW'(d_ec_q);
      sy_d = sy_d - SumW'(d_cn_q) - SumW'(d_ene_q);
    end
    if (dl_q) begin
      sx_d = sx_d - SumW'(d_cw_q) - SumW'(d_ssw_q);
      sy_d = sy_d - SumW'(d_sww_q) - SumW'(d_sc_q);
    end
    if (dr_q) begin
      sx_d = sx_d - SumW'(d_ec_q);
      sy_d = sy_d - SumW'(d_sc_q);
    end
  end

  // with no triangle, z of one unit scales to the straight-up normal
  assign cnt    = CntW'(ul_q) + CntW'({ur_q, 1'b0}) + CntW'({dl_q, 1'b0}) + CntW'(dr_q);
  assign cnt_nz = (cnt == '0) ? CntW'(1) : cnt;
  assign az_d   = AzW'(cnt_nz) << hvn_pkg::HEIGHT_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      az_q <= az_d;
    end
  end

  assign abx = sx_q[SumW-1] ? -sx_q : sx_q;
  assign aby = sy_q[SumW-1] ? -sy_q : sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx3_q <= sx_q[SumW-1];
      ny3_q <= sy_q[SumW-1];
      ax3_q <= LzW'(abx[MagW-1:0]);
      ay3_q <= LzW'(aby[MagW-1:0]);
      az3_q <= LzW'(az_q);
    end
  end

  assign orv = ax3_q | ay3_q | az3_q;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < LzW; i++) begin
      if (orv[i]) begin
        pos_d = PosW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q <= pos_d;
      nx4_q <= nx3_q;
      ny4_q <= ny3_q;
      ax4_q <= ax3_q;
      ay4_q <= ay3_q;
      az4_q <= az3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec5_q.nx <= nx4_q;
      vec5_q.ny <= ny4_q;
      vec5_q.ax <= norm_shift(ax4_q, pos_q);
      vec5_q.ay <= norm_shift(ay4_q, pos_q);
      vec5_q.az <= norm_shift(az4_q, pos_q);
      sqx_q     <= SqW'(vec5_q.ax) * SqW'(vec5_q.ax);
      sqy_q     <= SqW'(vec5_q.ay) * SqW'(vec5_q.ay);
      sqz_q     <= SqW'(vec5_q.az) * SqW'(vec5_q.az);
      vec6_q    <= vec5_q;
      len2_q    <= Len2W'(sqx_q) + Len2W'(sqy_q) + Len2W'(sqz_q);
      vec7_q    <= vec6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  hvn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .len2_i  (len2_q),
    .vec_i   (vec7_q),
    .valid_o (sq_v),
    .root_o  (root),
    .vec_o   (sq_vec)
  );

  hvn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .root_i  (root),
    .vec_i   (sq_vec),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while output stalled");

  a_z_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.normal_z <= Unit))
    else $error("normal_z above one");

  a_xy_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.normal_x <= Unit && out_data_o.normal_x >= -Unit &&
                     out_data_o.normal_y <= Unit && out_data_o.normal_y >= -Unit))
    else $error("normal_x or normal_y out of unit range");

endmodule

/* rtl/core/hvn_sqrt.sv */
// Pipelined integer square root, one root bit per stage, vector carried alongside.
// Depends on hvn_pkg.
module hvn_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [hvn_pkg::LEN2_BITS-1:0]    len2_i,
  input  hvn_pkg::vec_t                    vec_i,
  output logic                             valid_o,
  output logic [hvn_pkg::ROOT_BITS-1:0]    root_o,
  output hvn_pkg::vec_t                    vec_o
);

  localparam int RootW = hvn_pkg::ROOT_BITS;
  localparam int Len2W = hvn_pkg::LEN2_BITS;
  localparam int RemW  = RootW + 3;

  logic               v_q    [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [RemW-1:0]    rem_q  [RootW-1];
  logic [Len2W-1:0]   rad_q  [RootW-1];
  hvn_pkg::vec_t      vec_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int BI = 2 * (RootW - 1 - k);
    logic             v_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic [Len2W-1:0] rad_in;
    hvn_pkg::vec_t    vec_in;
    logic             fit;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = len2_i;
      assign vec_in  = vec_i;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign vec_in  = vec_q[k-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], rad_in[BI+1:BI]};
    assign trial  = RemW'({root_in, 2'b01});
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[RootW-2:0], fit};
        vec_q[k]  <= vec_in;
      end
    end

    if (k < RootW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= fit ? (rem_sh - trial) : rem_sh;
          rad_q[k] <= rad_in;
        end
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign vec_o   = vec_q[RootW-1];

endmodule

/* rtl/core/hvn_div.sv */
// Pipelined rounding divider: scales three magnitudes by the root, one quotient
// bit per stage, then applies signs into the result item. Depends on hvn_pkg.
module hvn_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [hvn_pkg::ROOT_BITS-1:0] root_i,
  input  hvn_pkg::vec_t                 vec_i,
  output logic                          valid_o,
  output hvn_pkg::out_t                 data_o
);

  localparam int RootW = hvn_pkg::ROOT_BITS;
  localparam int NumW  = hvn_pkg::NUM_BITS;
  localparam int QW    = hvn_pkg::Q_BITS;
  localparam int Frac  = hvn_pkg::OUT_FRAC;
  localparam int NxyW  = hvn_pkg::NXY_BITS;
  localparam int NzW   = hvn_pkg::NZ_BITS;
  localparam int Lanes = 3;
  localparam int LaneX = 0;
  localparam int LaneY = 1;
  localparam int LaneZ = 2;

  logic [hvn_pkg::NORM_BITS-1:0] mag [Lanes];

  logic             v_q   [QW+1];
  logic             nx_q  [QW+1];
  logic             ny_q  [QW+1];
  logic [RootW-1:0] den_q [QW];
  logic [NumW-1:0]  rem_q [QW][Lanes];
  logic [QW-1:0]    quo_q [1:QW][Lanes];

  logic             out_v_q;
  hvn_pkg::out_t    out_q;

  assign mag[LaneX] = vec_i.ax;
  assign mag[LaneY] = vec_i.ay;
  assign mag[LaneZ] = vec_i.az;

  // numerator: magnitude in output scale plus half the root for rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0]  <= vec_i.nx;
      ny_q[0]  <= vec_i.ny;
      den_q[0] <= root_i;
      for (int l = 0; l < Lanes; l++) begin
        rem_q[0][l] <= (NumW'(mag[l]) << Frac) + NumW'(root_i >> 1);
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int BI = QW - k;
    logic [NumW-1:0] dsh;

    assign dsh = NumW'(den_q[k-1]) << BI;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k] <= nx_q[k-1];
        ny_q[k] <= ny_q[k-1];
      end
    end

    if (k < QW) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_q[k-1];
        end
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic          fit;
      logic [QW-1:0] qin;

      assign fit = (rem_q[k-1][l] >= dsh);

      if (k == 1) begin : g_q0
        assign qin = '0;
      end else begin : g_qn
        assign qin = quo_q[k-1][l];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k][l] <= {qin[QW-2:0], fit};
        end
      end

      if (k < QW) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[k][l] <= fit ? (rem_q[k-1][l] - dsh) : rem_q[k-1][l];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.normal_x <= nx_q[QW] ? -NxyW'(quo_q[QW][LaneX]) : NxyW'(quo_q[QW][LaneX]);
      out_q.normal_y <= ny_q[QW] ? -NxyW'(quo_q[QW][LaneY]) : NxyW'(quo_q[QW][LaneY]);
      out_q.normal_z <= NzW'(quo_q[QW][LaneZ]);
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule
